// File: rtl/appliance_session_sequencer_assert.svh
// Assertion macros for the session sequencer
`ifndef APPLIANCE_SESSION_SEQUENCER_ASSERT_SVH
`define APPLIANCE_SESSION_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define APSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/apss_pkg.sv
// Types, codes and frame functions of the session sequencer
`timescale 1ns / 1ps
package apss_pkg;

   localparam logic [7:0] FRAME_SOF  = 8'h55;
   localparam logic [7:0] FRAME_EOF  = 8'hAA;
   localparam logic [7:0] LOGIN_MARK = 8'h2F;

   localparam logic [7:0] CODE_VERSION   = 8'h01;
   localparam logic [7:0] CODE_INFO      = 8'h03;
   localparam logic [7:0] CODE_STATS     = 8'h04;
   localparam logic [7:0] CODE_EXT       = 8'h05;
   localparam logic [7:0] CODE_POLL      = 8'h06;
   localparam logic [7:0] CODE_ARG_09    = 8'h09;
   localparam logic [7:0] CODE_ARG_0A    = 8'h0A;
   localparam logic [7:0] CODE_LEVEL     = 8'h0B;
   localparam logic [7:0] CODE_ARG_16    = 8'h16;
   localparam logic [7:0] CODE_ARG_1B    = 8'h1B;
   localparam logic [7:0] CODE_ARG_3C    = 8'h3C;
   localparam logic [7:0] CODE_STATS_ACK = 8'h47;
   localparam logic [7:0] CODE_SET_TIME  = 8'h6E;
   localparam logic [7:0] CODE_LOGIN     = 8'hFF;

   localparam logic [2:0] EV_RESPONSE  = 3'd0;
   localparam logic [2:0] EV_POLL_TICK = 3'd1;
   localparam logic [2:0] EV_LINK_UP   = 3'd2;
   localparam logic [2:0] EV_LINK_DOWN = 3'd3;
   localparam logic [2:0] EV_USER      = 3'd4;

   localparam logic [1:0] CSR_DEVICE_TYPE  = 2'd0;
   localparam logic [1:0] CSR_PEER_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_MODEL_PREFIX = 2'd2;
   localparam logic [1:0] CSR_UTC_SHIFT    = 2'd3;

   localparam int LEN_W       = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]         device_type;
      logic [47:0]        peer_address;
      logic [47:0]        model_prefix;
      logic signed [31:0] utc_shift;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  seq;
      logic [7:0]  code;
      logic [7:0]  arg;
      logic [31:0] now;
      logic        auth;
   } frame_desc_type;

   function automatic logic known_code(input logic [7:0] code);
      logic k;
      unique case (code)
         CODE_VERSION, CODE_INFO, CODE_STATS, CODE_EXT, CODE_POLL, CODE_ARG_09,
         CODE_ARG_0A, CODE_LEVEL, CODE_ARG_16, CODE_ARG_1B, CODE_ARG_3C,
         CODE_STATS_ACK, CODE_SET_TIME, CODE_LOGIN: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   function automatic logic [LEN_W-1:0] frame_len(input logic [7:0] code,
                                                  input logic [2:0] dtype);
      logic [LEN_W-1:0] n;
      unique case (code)
         CODE_EXT: n = dtype[0] ? LEN_W'(10) : LEN_W'(4);
         CODE_ARG_09, CODE_ARG_0A, CODE_ARG_16, CODE_ARG_1B, CODE_ARG_3C,
         CODE_STATS_ACK: n = LEN_W'(5);
         CODE_LEVEL: n = (dtype[2:1] != 2'b00) ? LEN_W'(6) : LEN_W'(5);
         CODE_SET_TIME, CODE_LOGIN: n = LEN_W'(12);
         default: n = LEN_W'(4);
      endcase
      return n;
   endfunction

   function automatic logic [7:0] frame_byte(input frame_desc_type d,
                                             input logic [LEN_W-1:0] idx,
                                             input logic [LEN_W-1:0] len,
                                             input cfg_type cfg);
      logic [7:0]       b;
      logic [LEN_W-1:0] k;
      logic [47:0]      mix;
      logic [5:0]       sh;
      b   = 8'h00;
      k   = '0;
      sh  = '0;
      mix = cfg.peer_address ^ cfg.model_prefix;
      if (idx == LEN_W'(0)) begin
         b = FRAME_SOF;
      end else if (idx == LEN_W'(1)) begin
         b = d.seq;
      end else if (idx == LEN_W'(2)) begin
         b = d.code;
      end else if (idx == len - LEN_W'(1)) begin
         b = FRAME_EOF;
      end else begin
         unique case (d.code)
            CODE_SET_TIME: begin
               if (idx < LEN_W'(7)) begin
                  k = idx - LEN_W'(3);
                  b = d.now[{k[1:0], 3'b000} +: 8];
               end else begin
                  k = idx - LEN_W'(7);
                  b = cfg.utc_shift[{k[1:0], 3'b000} +: 8];
               end
            end
            CODE_LOGIN: begin
               if (idx == LEN_W'(3) || idx == LEN_W'(10)) begin
                  b = LOGIN_MARK;
               end else begin
                  k  = idx - LEN_W'(4);
                  sh = 6'd40 - {k[2:0], 3'b000};
                  b  = mix[sh +: 8];
               end
            end
            CODE_STATS_ACK: b = 8'h00;
            default: b = (idx == LEN_W'(3)) ? d.arg : 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

// File: rtl/apss_if.sv
// Channel interfaces: event requests, frame bytes and register writes
`timescale 1ns / 1ps
interface apss_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  resp_seq;
   logic [7:0]  resp_code;
   logic [7:0]  resp_flag;
   logic [7:0]  request_code;
   logic [7:0]  request_arg;
   logic [31:0] now_time;
   modport source (output valid, cmd, resp_seq, resp_code, resp_flag, request_code,
                   request_arg, now_time, input ready);
   modport sink (input valid, cmd, resp_seq, resp_code, resp_flag, request_code,
                 request_arg, now_time, output ready);
endinterface

interface apss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   logic       authorized;
   modport source (output valid, frame_byte, last_byte, authorized, input ready);
   modport sink (input valid, frame_byte, last_byte, authorized, output ready);
endinterface

interface apss_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/apss_front.sv
// Event front end: session state, response checks and command choice
`timescale 1ns / 1ps
module apss_front (
   input  logic                    clock,
   input  logic                    reset,
   apss_req_if.sink                req_ch,
   input  logic                    q_full,
   output logic                    q_push,
   output apss_pkg::frame_desc_type q_desc
);
   import apss_pkg::*;

   logic [7:0] seq_ff, seq_in, seq_inc;
   logic       logged_ff, logged_in;
   logic       ready_ff, ready_in;
   logic [7:0] pend_code_ff, pend_code_in;
   logic [7:0] pend_arg_ff, pend_arg_in;
   logic       accept, send, match, ok;
   logic [7:0] cmd_code, cmd_arg;

   assign req_ch.ready = !q_full;
   assign accept  = req_ch.valid && req_ch.ready;
   assign match   = (req_ch.resp_seq == seq_ff);
   assign ok      = match && (req_ch.resp_flag != 8'h00);
   assign seq_inc = seq_ff + 8'd1;

   always_comb begin
      logged_in    = logged_ff;
      ready_in     = ready_ff;
      pend_code_in = pend_code_ff;
      pend_arg_in  = pend_arg_ff;
      send         = 1'b0;
      cmd_code     = CODE_POLL;
      cmd_arg      = 8'h00;
      unique case (req_ch.cmd)
         EV_RESPONSE: begin
            ready_in = 1'b0;
            unique case (req_ch.resp_code)
               CODE_VERSION: begin
                  send     = 1'b1;
                  cmd_code = ok ? CODE_SET_TIME : CODE_POLL;
               end
               CODE_STATS: begin
                  send     = 1'b1;
                  cmd_code = ok ? CODE_STATS_ACK : CODE_POLL;
               end
               CODE_POLL: ready_in = 1'b1;
               CODE_INFO, CODE_EXT, CODE_ARG_09, CODE_ARG_0A, CODE_LEVEL, CODE_ARG_16,
               CODE_ARG_1B, CODE_ARG_3C, CODE_STATS_ACK: send = 1'b1;
               CODE_SET_TIME: begin
                  send     = 1'b1;
                  cmd_code = (match && req_ch.resp_flag == 8'h00) ? CODE_STATS_ACK
                                                                  : CODE_POLL;
               end
               CODE_LOGIN: begin
                  send = 1'b1;
                  if (ok) begin
                     logged_in = 1'b1;
                     cmd_code  = CODE_VERSION;
                  end else begin
                     cmd_code  = CODE_LOGIN;
                  end
               end
               default: send = 1'b0;
            endcase
         end
         EV_POLL_TICK: begin
            if (logged_ff && ready_ff) begin
               send = 1'b1;
               if (pend_code_ff != 8'h00) begin
                  cmd_code     = pend_code_ff;
                  cmd_arg      = pend_arg_ff;
                  pend_code_in = 8'h00;
               end
            end
         end
         EV_LINK_UP: begin
            pend_code_in = 8'h00;
            send         = 1'b1;
            cmd_code     = CODE_LOGIN;
         end
         EV_LINK_DOWN: begin
            logged_in = 1'b0;
            ready_in  = 1'b0;
         end
         EV_USER: begin
            if (ready_ff) begin
               send     = 1'b1;
               cmd_code = req_ch.request_code;
               cmd_arg  = req_ch.request_arg;
            end else begin
               pend_code_in = req_ch.request_code;
               pend_arg_in  = req_ch.request_arg;
            end
         end
         default: send = 1'b0;
      endcase
      seq_in = seq_ff;
      if (send) begin
         ready_in = 1'b0;
         seq_in   = (seq_inc == 8'd0) ? 8'd1 : seq_inc;
      end
   end

   assign q_push      = accept && send && (logged_in || cmd_code == CODE_LOGIN);
   assign q_desc.seq  = seq_in;
   assign q_desc.code = known_code(cmd_code) ? cmd_code : CODE_POLL;
   assign q_desc.arg  = cmd_arg;
   assign q_desc.now  = req_ch.now_time;
   assign q_desc.auth = logged_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 8'd0;
         logged_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         pend_code_ff <= 8'h00;
         pend_arg_ff  <= 8'h00;
      end else if (accept) begin
         seq_ff       <= seq_in;
         logged_ff    <= logged_in;
         ready_ff     <= ready_in;
         pend_code_ff <= pend_code_in;
         pend_arg_ff  <= pend_arg_in;
      end
   end

endmodule

// File: rtl/apss_queue.sv
// Two-entry frame descriptor queue between front end and frame builder
`timescale 1ns / 1ps
module apss_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  apss_pkg::frame_desc_type push_desc,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output apss_pkg::frame_desc_type head
);
   import apss_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_desc_type   ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = ent_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

// File: rtl/apss_back.sv
// Frame builder: walks one descriptor a byte per cycle into the output register while rsp_ch is not stalled
`timescale 1ns / 1ps
module apss_back (
   input  logic                          clock,
   input  logic                          reset,
   input  apss_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   input  apss_pkg::frame_desc_type      q_head,
   output logic                          q_pop,
   apss_rsp_if.source                    rsp_ch
);
   import apss_pkg::*;

   logic [LEN_W-1:0] idx_ff, idx_in, len;
   logic             valid_ff;
   logic [7:0]       byte_ff;
   logic             last_ff, auth_ff;
   logic             load, take, at_last;

   assign load    = !valid_ff || rsp_ch.ready;
   assign take    = load && !q_empty;
   assign len     = frame_len(q_head.code, cfg.device_type);
   assign at_last = (idx_ff == len - LEN_W'(1));
   assign q_pop   = take && at_last;
   assign idx_in  = at_last ? '0 : idx_ff + LEN_W'(1);

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.frame_byte = byte_ff;
   assign rsp_ch.last_byte  = last_ff;
   assign rsp_ch.authorized = auth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= !q_empty;
         end
         if (take) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= frame_byte(q_head, idx_ff, len, cfg);
         last_ff <= at_last;
         auth_ff <= q_head.auth;
      end
   end

endmodule

// File: rtl/appliance_session_sequencer.sv
// Top level of the appliance session sequencer
//
//   port     role    moves
//   req_ch   sink    one event request (response, tick, link up/down, user)
//   rsp_ch   source  one frame byte with last and authorized flags
//   csr_ch   sink    one register write (index, data), always ready
//
// An event request is taken while the queue is not full; one that starts a
// frame queues a descriptor, and the frame builder then sends one byte per
// cycle while rsp_ch is ready, 4 to 12 bytes a frame, so the byte output port sets the sustained rate.
// The two-entry queue and the output register let events keep arriving while
// a frame drains. Synchronous reset clears the session state and registers.
`timescale 1ns / 1ps
`include "appliance_session_sequencer_assert.svh"
module appliance_session_sequencer (
   input  logic       clock,
   input  logic       reset,
   apss_req_if.sink   req_ch,
   apss_rsp_if.source rsp_ch,
   apss_csr_if.sink   csr_ch
);
   import apss_pkg::*;

   cfg_type        cfg_ff;
   logic           q_push, q_pop, q_full, q_empty;
   frame_desc_type q_desc, q_head;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DEVICE_TYPE:  cfg_ff.device_type  <= csr_ch.data[2:0];
            CSR_PEER_ADDRESS: cfg_ff.peer_address <= csr_ch.data;
            CSR_MODEL_PREFIX: cfg_ff.model_prefix <= csr_ch.data;
            CSR_UTC_SHIFT:    cfg_ff.utc_shift    <= $signed(csr_ch.data[31:0]);
            default:          cfg_ff.device_type  <= cfg_ff.device_type;
         endcase
      end
   end

   apss_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_desc (q_desc)
   );

   apss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   apss_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   `APSS_ASSERT_NOW(a_no_overflow, clock, reset, q_push, !q_full, "push into full queue")
   `APSS_ASSERT_NOW(a_seq_nonzero, clock, reset, q_push, q_desc.seq != 8'd0, "zero sequence")
   `APSS_ASSERT_NOW(a_last_is_eof, clock, reset, rsp_ch.valid && rsp_ch.last_byte, rsp_ch.frame_byte == FRAME_EOF, "frame does not close with end byte")
   `APSS_ASSERT_NEXT(a_next_is_sof, clock, reset, rsp_ch.valid && rsp_ch.ready && rsp_ch.last_byte, !rsp_ch.valid || rsp_ch.frame_byte == FRAME_SOF, "frame does not open with start byte")

endmodule

// File: dv/apss_session_checker.sv
// Session checker: predicts the frame bytes of each request and compares them with the DUT
`timescale 1ns / 1ps
module apss_session_checker (
   input  logic        clock,
   input  logic        reset,
   apss_req_if         req_mon,
   apss_rsp_if         rsp_mon,
   apss_csr_if         csr_mon,
   output int unsigned mismatch_total,
   output int unsigned bytes_owed,
   output int unsigned bytes_checked,
   output int unsigned frames_checked,
   output logic [7:0]  seq_now,
   output logic [7:0]  last_code,
   output logic        session_open,
   output logic        link_ready
);
   import apss_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       auth;
   } frame_beat_type;

   frame_beat_type owed_q[$];
   cfg_type     cfg;
   logic [7:0]  seq_ctr;
   logic [7:0]  pend_code;
   logic [7:0]  pend_arg;
   logic [7:0]  sent_code;
   logic        logged;
   logic        ready_f;
   int unsigned miss;
   int unsigned beats;
   int unsigned frames;

   function automatic bit note_miss();
      miss++;
      return miss <= 10;
   endfunction

   function automatic void send_command(input logic [7:0] code, input logic [7:0] arg,
                                        input logic [31:0] now);
      logic [7:0]  fr [0:11];
      logic [47:0] mix;
      int          len;
      ready_f = 1'b0;
      seq_ctr = seq_ctr + 8'd1;
      if (seq_ctr == 8'd0) seq_ctr = 8'd1;
      foreach (fr[i]) fr[i] = 8'h00;
      mix   = cfg.peer_address ^ cfg.model_prefix;
      fr[0] = FRAME_SOF;
      fr[1] = seq_ctr;
      fr[2] = code;
      len   = 4;
      case (code)
         CODE_VERSION, CODE_INFO, CODE_STATS, CODE_POLL: len = 4;
         CODE_EXT: begin
            if (cfg.device_type[0]) begin
               fr[3] = arg;
               len   = 10;
            end
         end
         CODE_ARG_09, CODE_ARG_0A, CODE_ARG_16, CODE_ARG_1B, CODE_ARG_3C: begin
            fr[3] = arg;
            len   = 5;
         end
         CODE_LEVEL: begin
            fr[3] = arg;
            len   = (cfg.device_type[2:1] != 2'b00) ? 6 : 5;
         end
         CODE_STATS_ACK: len = 5;
         CODE_SET_TIME: begin
            for (int i = 0; i < 4; i++) begin
               fr[3 + i] = now[8 * i +: 8];
               fr[7 + i] = cfg.utc_shift[8 * i +: 8];
            end
            len = 12;
         end
         CODE_LOGIN: begin
            fr[3] = LOGIN_MARK;
            for (int i = 0; i < 6; i++) fr[4 + i] = mix[40 - 8 * i +: 8];
            fr[10] = LOGIN_MARK;
            len    = 12;
         end
         default: begin
            fr[2] = CODE_POLL;
            len   = 4;
         end
      endcase
      fr[len - 1] = FRAME_EOF;
      sent_code   = fr[2];
      if (logged || code == CODE_LOGIN) begin
         for (int i = 0; i < len; i++)
            owed_q.push_back('{data: fr[i], last: (i == len - 1), auth: logged});
      end
   endfunction

   function automatic void take_event(input logic [2:0] ev, input logic [7:0] rseq,
                                      input logic [7:0] rcode, input logic [7:0] rflag,
                                      input logic [7:0] qcode, input logic [7:0] qarg,
                                      input logic [31:0] now);
      logic       match;
      logic       ok;
      logic [7:0] held;
      match = (rseq == seq_ctr);
      ok    = match && (rflag != 8'h00);
      case (ev)
         EV_RESPONSE: begin
            ready_f = 1'b0;
            case (rcode)
               CODE_VERSION: send_command(ok ? CODE_SET_TIME : CODE_POLL, 8'h00, now);
               CODE_INFO: send_command(CODE_POLL, 8'h00, now);
               CODE_STATS: send_command(ok ? CODE_STATS_ACK : CODE_POLL, 8'h00, now);
               CODE_POLL: ready_f = 1'b1;
               CODE_EXT, CODE_ARG_09, CODE_ARG_0A, CODE_LEVEL, CODE_ARG_16, CODE_ARG_1B,
               CODE_ARG_3C, CODE_STATS_ACK: send_command(CODE_POLL, 8'h00, now);
               CODE_SET_TIME: begin
                  send_command((match && rflag == 8'h00) ? CODE_STATS_ACK : CODE_POLL,
                               8'h00, now);
               end
               CODE_LOGIN: begin
                  if (ok) begin
                     logged = 1'b1;
                     send_command(CODE_VERSION, 8'h00, now);
                  end else begin
                     send_command(CODE_LOGIN, 8'h00, now);
                  end
               end
               default: ;
            endcase
         end
         EV_POLL_TICK: begin
            if (logged && ready_f) begin
               if (pend_code != 8'h00) begin
                  held      = pend_code;
                  pend_code = 8'h00;
                  send_command(held, pend_arg, now);
               end else begin
                  send_command(CODE_POLL, 8'h00, now);
               end
            end
         end
         EV_LINK_UP: begin
            pend_code = 8'h00;
            send_command(CODE_LOGIN, 8'h00, now);
         end
         EV_LINK_DOWN: begin
            logged  = 1'b0;
            ready_f = 1'b0;
         end
         EV_USER: begin
            if (ready_f) begin
               send_command(qcode, qarg, now);
            end else begin
               pend_code = qcode;
               pend_arg  = qarg;
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      frame_beat_type got;
      frame_beat_type want;
      if (reset) begin
         cfg       = '0;
         seq_ctr   = 8'h00;
         pend_code = 8'h00;
         pend_arg  = 8'h00;
         sent_code = 8'h00;
         logged    = 1'b0;
         ready_f   = 1'b0;
         miss      = 0;
         beats     = 0;
         frames    = 0;
         owed_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_DEVICE_TYPE:  cfg.device_type  = csr_mon.data[2:0];
               CSR_PEER_ADDRESS: cfg.peer_address = csr_mon.data;
               CSR_MODEL_PREFIX: cfg.model_prefix = csr_mon.data;
               CSR_UTC_SHIFT:    cfg.utc_shift    = csr_mon.data[31:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{data: rsp_mon.frame_byte, last: rsp_mon.last_byte,
                    auth: rsp_mon.authorized};
            if (owed_q.size() == 0) begin
               if (note_miss())
                  $display("%0t: frame byte %02h last %0b auth %0b with nothing expected",
                           $realtime, got.data, got.last, got.auth);
            end else begin
               want = owed_q.pop_front();
               if (got.data !== want.data || got.last !== want.last ||
                   got.auth !== want.auth) begin
                  if (note_miss())
                     $display("%0t: byte %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                              $realtime, beats, want.data, want.last, want.auth,
                              got.data, got.last, got.auth);
               end
               beats++;
               if (want.last) frames++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            take_event(req_mon.cmd, req_mon.resp_seq, req_mon.resp_code, req_mon.resp_flag,
                       req_mon.request_code, req_mon.request_arg, req_mon.now_time);
      end
      mismatch_total <= miss;
      bytes_owed     <= owed_q.size();
      bytes_checked  <= beats;
      frames_checked <= frames;
      seq_now        <= seq_ctr;
      last_code      <= sent_code;
      session_open   <= logged;
      link_ready     <= ready_f;
   end

endmodule

// File: dv/tb_appliance_session_sequencer.sv
// Testbench top: drives session events and register writes, checks frames, reports verdict
`timescale 1ns / 1ps
module tb_appliance_session_sequencer;
   import apss_pkg::*;

   localparam int          WATCHDOG_LIMIT  = 4000;
   localparam int          SETTLE_CYCLES   = 32;
   localparam int          ITEMS_PER_PHASE = 112;
   localparam logic [2:0]  EV_SPARE        = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   apss_req_if req_bus ();
   apss_rsp_if rsp_bus ();
   apss_csr_if csr_bus ();

   int unsigned mismatch_total;
   int unsigned bytes_owed;
   int unsigned bytes_checked;
   int unsigned frames_checked;
   logic [7:0]  seq_now;
   logic [7:0]  last_code;
   logic        session_open;
   logic        link_ready;

   int unsigned sender_idle_pct    = 13;
   int unsigned receiver_stall_pct = 78;
   int unsigned requests_sent      = 0;
   int unsigned quiet_cycles       = 0;

   appliance_session_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   apss_session_checker session_chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_total (mismatch_total),
      .bytes_owed     (bytes_owed),
      .bytes_checked  (bytes_checked),
      .frames_checked (frames_checked),
      .seq_now        (seq_now),
      .last_code      (last_code),
      .session_open   (session_open),
      .link_ready     (link_ready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_code();
      logic [7:0] c;
      case ($urandom_range(16))
         0:  c = CODE_VERSION;
         1:  c = CODE_INFO;
         2:  c = CODE_STATS;
         3:  c = CODE_EXT;
         4:  c = CODE_POLL;
         5:  c = CODE_ARG_09;
         6:  c = CODE_ARG_0A;
         7:  c = CODE_LEVEL;
         8:  c = CODE_ARG_16;
         9:  c = CODE_ARG_1B;
         10: c = CODE_ARG_3C;
         11: c = CODE_STATS_ACK;
         12: c = CODE_SET_TIME;
         13: c = CODE_LOGIN;
         default: c = 8'($urandom);
      endcase
      return c;
   endfunction

   task automatic send_request(input logic [2:0] ev, input logic [7:0] rseq,
                               input logic [7:0] rcode, input logic [7:0] rflag,
                               input logic [7:0] qcode, input logic [7:0] qarg,
                               input logic [31:0] now);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= ev;
      req_bus.resp_seq     <= rseq;
      req_bus.resp_code    <= rcode;
      req_bus.resp_flag    <= rflag;
      req_bus.request_code <= qcode;
      req_bus.request_arg  <= qarg;
      req_bus.now_time     <= now;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   task automatic drain_frames();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (bytes_owed != 0);
   endtask

   task automatic settle();
      drain_frames();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic fire(input logic [2:0] ev, input logic [7:0] qcode, input logic [7:0] qarg);
      send_request(ev, 8'($urandom), 8'($urandom), 8'($urandom), qcode, qarg, $urandom);
   endtask

   task automatic answer(input logic [7:0] code, input logic [7:0] flag, input bit seq_ok,
                         input logic [31:0] now);
      drain_frames();
      send_request(EV_RESPONSE, seq_ok ? seq_now : seq_now ^ 8'h5A, code, flag,
                   8'($urandom), 8'($urandom), now);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [2:0] dtype, input logic [47:0] peer,
                              input logic [47:0] model, input logic [31:0] tz);
      write_reg(CSR_DEVICE_TYPE, {45'd0, dtype});
      write_reg(CSR_PEER_ADDRESS, peer);
      write_reg(CSR_MODEL_PREFIX, model);
      write_reg(CSR_UTC_SHIFT, {16'd0, tz});
   endtask

   task automatic session_step();
      drain_frames();
      if (!session_open) begin
         if (last_code == CODE_LOGIN && $urandom_range(3) != 0)
            answer(CODE_LOGIN, 8'($urandom_range(255, 1)), 1'b1, $urandom);
         else
            fire(EV_LINK_UP, 8'($urandom), 8'($urandom));
      end else if (link_ready) begin
         case ($urandom_range(9))
            0, 1: fire(EV_POLL_TICK, 8'($urandom), 8'($urandom));
            2: fire(EV_LINK_DOWN, 8'($urandom), 8'($urandom));
            default: begin
               fire(EV_USER, pick_code(), 8'($urandom));
               if ($urandom_range(3) == 0) fire(EV_USER, pick_code(), 8'($urandom));
            end
         endcase
      end else if ($urandom_range(9) == 0) begin
         fire(EV_USER, pick_code(), 8'($urandom));
      end else begin
         answer(last_code, (last_code == CODE_SET_TIME) ? 8'h00 : 8'($urandom_range(255, 1)),
                1'b1, $urandom);
      end
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 22)
            send_request(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), $urandom);
         else if (pick < 30)
            answer(pick_code(), 8'($urandom), 1'($urandom_range(1)), $urandom);
         else
            session_step();
      end
   endtask

   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= EV_RESPONSE;
      req_bus.resp_seq     <= 8'h00;
      req_bus.resp_code    <= 8'h00;
      req_bus.resp_flag    <= 8'h00;
      req_bus.request_code <= 8'h00;
      req_bus.request_arg  <= 8'h00;
      req_bus.now_time     <= 32'h0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_DEVICE_TYPE;
      csr_bus.data         <= 48'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_config(3'd1, 48'h0123_4567_89AB, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
      fire(EV_LINK_DOWN, 8'h00, 8'h00);
      fire(EV_USER, CODE_LEVEL, 8'hFF);
      fire(EV_POLL_TICK, 8'h00, 8'h00);
      answer(CODE_POLL, 8'h00, 1'b1, 32'h0);
      fire(EV_USER, CODE_ARG_09, 8'h00);
      fire(EV_LINK_UP, 8'h00, 8'h00);
      answer(CODE_LOGIN, 8'h01, 1'b0, 32'h0);
      answer(CODE_LOGIN, 8'h00, 1'b1, 32'h0);
      answer(CODE_LOGIN, 8'hFF, 1'b1, 32'h0);
      answer(CODE_VERSION, 8'h80, 1'b1, 32'hFFFF_FFFF);
      answer(CODE_SET_TIME, 8'h00, 1'b1, 32'h0);
      answer(CODE_STATS_ACK, 8'h12, 1'b1, 32'h0);
      answer(CODE_POLL, 8'hFF, 1'b1, 32'h0);
      fire(EV_POLL_TICK, 8'h00, 8'h00);
      answer(CODE_POLL, 8'h00, 1'b1, 32'h0);
      fire(EV_USER, CODE_EXT, 8'hAB);
      fire(EV_USER, CODE_LEVEL, 8'h5A);
      answer(CODE_POLL, 8'h01, 1'b1, 32'h0);
      fire(EV_POLL_TICK, 8'h00, 8'h00);
      fire(EV_USER, 8'h00, 8'h33);
      answer(CODE_POLL, 8'h01, 1'b1, 32'h0);
      fire(EV_POLL_TICK, 8'h00, 8'h00);
      answer(CODE_POLL, 8'h01, 1'b1, 32'h0);
      fire(EV_USER, 8'h77, 8'h11);
      answer(8'h99, 8'h01, 1'b1, 32'h0);
      answer(CODE_STATS, 8'h00, 1'b1, 32'h0);
      answer(CODE_SET_TIME, 8'h01, 1'b1, 32'h0);
      fire(EV_SPARE, 8'hFF, 8'hFF);
      fire(EV_LINK_DOWN, 8'h00, 8'h00);

      settle();
      load_config(3'd0, 48'h0, 48'h0, 32'h0);
      run_phase(ITEMS_PER_PHASE);

      settle();
      sender_idle_pct    <= 78;
      receiver_stall_pct <= 13;
      load_config(3'd7, 48'hFFFF_FFFF_FFFF, 48'h0, 32'h7FFF_FFFF);
      run_phase(ITEMS_PER_PHASE);

      settle();
      sender_idle_pct    <= 0;
      receiver_stall_pct <= 0;
      load_config(3'($urandom_range(7)), {16'($urandom), 32'($urandom)},
                  {16'($urandom), 32'($urandom)}, $urandom);
      run_phase(ITEMS_PER_PHASE);

      drain_frames();
      repeat (40) @(posedge clock);
      $display("Covered %0d event requests: %0d frames, %0d bytes checked,", requests_sent,
               frames_checked, bytes_checked);
      $display("across login, time, stats, poll and user commands under four register sets");
      if (mismatch_total == 0 && bytes_owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/apss_pkg.sv
rtl/apss_if.sv
rtl/apss_front.sv
rtl/apss_queue.sv
rtl/apss_back.sv
rtl/appliance_session_sequencer.sv
dv/apss_session_checker.sv
dv/tb_appliance_session_sequencer.sv
